FILE: sv/swmf_pkg.sv
// shared types for the sliding window median filter
// command and status groups between controller and datapath, default sizes
// no dependencies
package swmf_pkg;

   localparam int WINDOW_DEFAULT      = 5;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // controller to datapath
   typedef struct packed {
      logic load;   // write the accepted sample, restart the candidate scan
      logic step;   // rank the current candidate, advance to the next
      logic emit;   // copy the found median into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_cand;  // current candidate is the last valid slot
   } status_type;

endpackage

FILE: sv/swmf_ctrl.sv
// controller for the sliding window median filter
// sequences accept, candidate scan, pipeline drain and result hand-off
// depends on swmf_pkg
module swmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  swmf_pkg::status_type  status,
   output swmf_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (status.last_cand) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/swmf_datapath.sv
// datapath for the sliding window median filter
// circular window, fill count, rank-by-count candidate scan, output register
// depends on swmf_pkg
module swmf_datapath #(
   parameter int WINDOW      = swmf_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swmf_pkg::cmd_type             cmd,
   output swmf_pkg::status_type          status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_median
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);

   logic signed [SAMPLE_BITS-1:0] win_ff [WINDOW];
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic [IDX_W-1:0]              cand_ff;
   logic [WINDOW-1:0]             mask_ff, mask_in;
   logic                          mask_vld_ff;
   logic signed [SAMPLE_BITS-1:0] cand_val_ff, cand_v;
   logic signed [SAMPLE_BITS-1:0] found_ff;
   logic signed [SAMPLE_BITS-1:0] median_ff;
   logic [CNT_W-1:0]              rank;
   logic [CNT_W-1:0]              target;

   assign cand_v = win_ff[cand_ff];
   assign target = fill_ff >> 1;

   assign slot_in = (slot_ff == IDX_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign fill_in = (fill_ff == CNT_W'(WINDOW)) ? fill_ff : fill_ff + 1'b1;

   assign status.last_cand = ((CNT_W'(cand_ff) + 1'b1) == fill_ff);

   // a valid slot counts below the candidate if smaller, or equal and at a lower index
   always_comb begin
      for (int j = 0; j < WINDOW; j++) begin
         mask_in[j] = (CNT_W'(j) < fill_ff) &&
                      ((win_ff[j] < cand_v) ||
                       ((IDX_W'(j) < cand_ff) && (win_ff[j] == cand_v)));
      end
   end

   always_comb begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
         rank = rank + CNT_W'(mask_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         cand_ff     <= '0;
         mask_vld_ff <= 1'b0;
      end else begin
         mask_vld_ff <= cmd.step;
         if (cmd.load) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
            cand_ff <= '0;
         end else if (cmd.step) begin
            cand_ff <= cand_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) win_ff[slot_ff] <= req_sample;
      if (cmd.step) begin
         mask_ff     <= mask_in;
         cand_val_ff <= cand_v;
      end
      if (mask_vld_ff && (rank == target)) found_ff <= cand_val_ff;
      if (cmd.emit) median_ff <= found_ff;
   end

   assign rsp_median = median_ff;

endmodule

FILE: sv/sliding_window_median_filter.sv
// top level of the sliding window median filter
// ties controller and datapath together, holds the checks
// depends on swmf_pkg, swmf_ctrl, swmf_datapath
//
// One signed sample goes in per request and one median comes out for it: the
// median of the samples now in the window of the last WINDOW, taking the upper
// middle value whenever the count of valid samples is even. A request passes
// through accept, where the sample is written, a scan that ranks each valid
// slot (1 to WINDOW, 5 at the default window once full) in turn against all
// others in parallel, a drain state that settles the last rank count, and a
// hand-off that waits while an earlier result is still stalled. The next
// request is taken as soon as the result sits in the output register, even
// while the receiver stalls it. Window contents need no clearing after reset.
module sliding_window_median_filter #(
   parameter int WINDOW      = swmf_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_median
);

   swmf_pkg::cmd_type    cmd;
   swmf_pkg::status_type status;

   // sequencing of accept, scan and hand-off
   swmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // window storage and rank counting
   swmf_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_sample),
      .rsp_median (rsp_median)
   );

   // a request starts a scan, so the input closes right after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not closed after a request was taken");

   // handing over a result always raises the output valid
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result handed over without output valid");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && rsp_valid && rsp_stall))
      else $error("pending result overwritten");

   // the datapath never loads and scans in the same cycle
   a_load_step_apart: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("load and scan step together");

endmodule
